// ===== rtl/sdt_pkg.sv =====
// sdt_pkg: shared types, widths and helpers for the scan report dedup table.
// Used by sdt_cell and scan_report_dedup_table; depends on nothing.
package sdt_pkg;

  // fixed field widths and the default table depth
  localparam int ADDR_W           = 48;
  localparam int BYTE_W           = 8;
  localparam int PHY_W            = 16;
  localparam int SLOT_OUT_W       = 4;
  localparam int COUNT_OUT_W      = 5;
  localparam int DEF_TABLE_DEPTH  = 16;

  // item kind
  typedef enum logic {
    MODE_REPORT = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_t;

  // word that walks down the cell row
  typedef struct packed {
    mode_t               mode;
    logic [ADDR_W-1:0]   key;
    logic [BYTE_W-1:0]   strength;
    logic [BYTE_W-1:0]   kind;
    logic [PHY_W-1:0]    phy;
  } item_t;

  // search status carried along with the word
  typedef struct packed {
    logic found;
    logic written;
  } status_t;

  // received byte 0 ends up in bits 47..40
  function automatic logic [ADDR_W-1:0] reverse_bytes48(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int b = 0; b < ADDR_W / BYTE_W; b++) begin
      r[BYTE_W*(ADDR_W/BYTE_W-1-b) +: BYTE_W] = a[BYTE_W*b +: BYTE_W];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sdt_cell.sv =====
// sdt_cell: one table entry plus the pipeline register that hands the word on.
// Depends on sdt_pkg.
module sdt_cell #(
  parameter int TABLE_DEPTH = sdt_pkg::DEF_TABLE_DEPTH,
  parameter int IDX         = 0,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int SLOT_W     = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [CNT_W-1:0]    count,
  input  logic                in_vld,
  input  sdt_pkg::item_t      in_item,
  input  sdt_pkg::status_t    in_st,
  input  logic [SLOT_W-1:0]   in_slot,
  output logic                out_vld,
  output sdt_pkg::item_t      out_item,
  output sdt_pkg::status_t    out_st,
  output logic [SLOT_W-1:0]   out_slot
);

  // entry contents, meaningful only below count
  logic [sdt_pkg::ADDR_W-1:0] entry_addr;
  logic [sdt_pkg::BYTE_W-1:0] entry_strength;
  logic [sdt_pkg::BYTE_W-1:0] entry_kind;
  logic [sdt_pkg::PHY_W-1:0]  entry_phy;

  logic              is_report;
  logic              hit;
  logic              put;
  sdt_pkg::status_t  st_next;
  logic [SLOT_W-1:0] slot_next;

  // compare against a live entry, or claim the first free one
  always_comb begin
    is_report = in_vld && (in_item.mode == sdt_pkg::MODE_REPORT);
    hit = is_report && !in_st.found && !in_st.written
          && (CNT_W'(IDX) < count) && (entry_addr == in_item.key);
    put = is_report && !in_st.found && (CNT_W'(IDX) == count);
    st_next.found   = in_st.found | hit;
    st_next.written = in_st.written | put;
    slot_next = (hit || put) ? SLOT_W'(IDX) : in_slot;
  end

  // word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= in_item;
      out_st   <= st_next;
      out_slot <= slot_next;
    end
  end

  // entry write
  always_ff @(posedge clk) begin
    if (advance && put) begin
      entry_addr     <= in_item.key;
      entry_strength <= in_item.strength;
      entry_kind     <= in_item.kind;
      entry_phy      <= in_item.phy;
    end
  end

endmodule

// ===== rtl/scan_report_dedup_table.sv =====
// scan_report_dedup_table: insert-if-absent table of advertising addresses.
// Depends on sdt_pkg and sdt_cell.
//
// Input channel (in_valid / in_stall) takes one word per item: mode selects
// a report or a clear. A report's byte-reversed address is checked against
// the live entries; an unknown address is appended, a known one is reported
// with its slot, and a new address at a full table is dropped with
// dropped_full set. A clear empties the table.
// The word walks a row of TABLE_DEPTH cells, each cell holding one entry,
// one cell per cycle while the row is not held. The next item is taken
// only after the word leaves the row; the row carries one item at a time.
// Output channel (out_valid / out_stall) holds the result in a register; a
// stalled result stays put, and a word that reaches the end of the row waits
// in the last cell until the register is free.
// Reset empties the table and the row; entries are not cleared.
module scan_report_dedup_table #(
  parameter int TABLE_DEPTH = sdt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic [sdt_pkg::ADDR_W-1:0]            device_address,
  input  logic signed [sdt_pkg::BYTE_W-1:0]     signal_strength,
  input  logic [sdt_pkg::BYTE_W-1:0]            addr_kind,
  input  logic [sdt_pkg::BYTE_W-1:0]            first_phy,
  input  logic [sdt_pkg::BYTE_W-1:0]            second_phy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  is_new,
  output logic                                  dropped_full,
  output logic [sdt_pkg::SLOT_OUT_W-1:0]        slot,
  output logic [sdt_pkg::COUNT_OUT_W-1:0]       entry_count
);

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 advance;
  logic                 retire;
  sdt_pkg::item_t       head_item;

  // row links, index k is the input of cell k
  logic                 link_vld  [TABLE_DEPTH+1];
  sdt_pkg::item_t       link_item [TABLE_DEPTH+1];
  sdt_pkg::status_t     link_st   [TABLE_DEPTH+1];
  logic [SLOT_W-1:0]    link_slot [TABLE_DEPTH+1];

  // input side
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  always_comb begin
    head_item.mode     = sdt_pkg::mode_t'(mode);
    head_item.key      = sdt_pkg::reverse_bytes48(device_address);
    head_item.strength = signal_strength;
    head_item.kind     = addr_kind;
    head_item.phy      = {second_phy, first_phy};
  end

  assign link_vld[0]  = accept;
  assign link_item[0] = head_item;
  assign link_st[0]   = '0;
  assign link_slot[0] = '0;

  // the row holds only while its last cell waits on a stalled result
  assign advance = !(link_vld[TABLE_DEPTH] && out_valid && out_stall);
  assign retire  = link_vld[TABLE_DEPTH] && advance;

  // cell row
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    sdt_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX         (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .count    (count),
      .in_vld   (link_vld[k]),
      .in_item  (link_item[k]),
      .in_st    (link_st[k]),
      .in_slot  (link_slot[k]),
      .out_vld  (link_vld[k+1]),
      .out_item (link_item[k+1]),
      .out_st   (link_st[k+1]),
      .out_slot (link_slot[k+1])
    );
  end

  // fill count after the retiring item
  always_comb begin
    count_next = count;
    if (link_item[TABLE_DEPTH].mode == sdt_pkg::MODE_CLEAR) begin
      count_next = '0;
    end else if (link_st[TABLE_DEPTH].written) begin
      count_next = count + CNT_W'(1);
    end
  end

  // busy from accept until the word leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (retire) begin
        busy <= 1'b0;
      end
      if (retire) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      is_new       <= link_st[TABLE_DEPTH].written;
      dropped_full <= (link_item[TABLE_DEPTH].mode == sdt_pkg::MODE_REPORT)
                      && !link_st[TABLE_DEPTH].found && !link_st[TABLE_DEPTH].written;
      slot         <= sdt_pkg::SLOT_OUT_W'(link_slot[TABLE_DEPTH]);
      entry_count  <= sdt_pkg::COUNT_OUT_W'(count_next);
    end
  end

  // checks
  a_new_xor_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && dropped_full))
    else $error("new and dropped reported together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count above table depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    retire && !link_st[TABLE_DEPTH].found && !link_st[TABLE_DEPTH].written
    && (link_item[TABLE_DEPTH].mode == sdt_pkg::MODE_REPORT)
    |-> count == CNT_W'(TABLE_DEPTH))
    else $error("report dropped while table not full");

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !accept)
    else $error("second word entered the row");

endmodule
